>>> hdl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

   localparam int OUT_WIDTH    = 32;
   localparam int STATUS_WIDTH = 2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_WRAP  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_NUM  = 5'b00010,
      ST_DEN  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

>>> hdl/pcc_div.sv
`default_nettype none

module pcc_div #(
   parameter int RESULT_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [RESULT_WIDTH-1:0] dividend,
   input  wire logic [RESULT_WIDTH-1:0] divisor,
   output logic                         done,
   output logic [RESULT_WIDTH-1:0]      quotient
);

   localparam int CW = $clog2(RESULT_WIDTH + 1);

   logic                    busy_ff, busy_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [RESULT_WIDTH-1:0] quo_ff, quo_in;
   logic [RESULT_WIDTH-1:0] rem_ff, rem_in;
   logic [RESULT_WIDTH-1:0] den_ff, den_in;
   logic [RESULT_WIDTH:0]   shifted;
   logic [RESULT_WIDTH:0]   trial;

   // one restoring step per cycle, quotient bits shift in from the bottom
   assign shifted = {rem_ff, quo_ff[RESULT_WIDTH-1]};
   assign trial   = shifted - {1'b0, den_ff};

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(RESULT_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (!trial[RESULT_WIDTH]) begin
               rem_in = trial[RESULT_WIDTH-1:0];
               quo_in = {quo_ff[RESULT_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = shifted[RESULT_WIDTH-1:0];
               quo_in = {quo_ff[RESULT_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

`default_nettype wire

>>> hdl/permutation_combination_counter.sv
// permutation_combination_counter
// request word (req_valid/req_ready): mode, n, r. mode 0 asks for the falling
// factorial n!/(n-r)!, mode 1 for the binomial coefficient C(n,r).
// response word (rsp_valid/rsp_ready): result and status (0 ok, 1 r above n,
// 2 a partial product wrapped modulo 2^RESULT_WIDTH).
// one request is in work at a time; req_ready is high only while idle.
// a shared RESULT_WIDTH x COUNT_WIDTH multiplier forms one factor per cycle,
// then, in mode 1, a radix-2 divider takes one quotient bit per cycle.
// r above n goes from idle straight to the output state; mode 0 multiplies
// r factors; mode 1 multiplies k = min(r, n-r) factors for the numerator,
// then k for the denominator, then divides, and skips the division when
// the divisor wrapped to zero.
// the block returns to idle at the same edge that loads the response.
// a stalled response is held in its output register; the block can take
// and finish the next request, then waits until the held word is taken.
// reset (synchronous, active high) returns to idle and drops rsp_valid.
`default_nettype none

module permutation_combination_counter #(
   parameter int COUNT_WIDTH  = 8,
   parameter int RESULT_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_mode,
   input  wire logic [COUNT_WIDTH-1:0]             req_n,
   input  wire logic [COUNT_WIDTH-1:0]             req_r,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [pcc_pkg::OUT_WIDTH-1:0]           rsp_result,
   output logic [pcc_pkg::STATUS_WIDTH-1:0]        rsp_status
);

   import pcc_pkg::*;

   localparam int PW = RESULT_WIDTH + COUNT_WIDTH;

   state_type               state_ff, state_in;
   logic                    mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0]  f_ff, f_in;
   logic [COUNT_WIDTH-1:0]  k_ff, k_in;
   logic [RESULT_WIDTH-1:0] p_ff, p_in;
   logic [RESULT_WIDTH-1:0] num_ff, num_in;
   logic                    wrap_ff, wrap_in;
   logic [RESULT_WIDTH-1:0] res_ff, res_in;
   logic [STATUS_WIDTH-1:0] st_ff, st_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]    rsp_result_ff, rsp_result_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic [PW-1:0]           prod;
   logic                    prod_wrap;
   logic [COUNT_WIDTH-1:0]  n_minus_r;
   logic [COUNT_WIDTH-1:0]  k_sel;
   logic [63:0]             res_ext;
   logic                    div_start;
   logic                    div_done;
   logic [RESULT_WIDTH-1:0] div_quo;
   logic [STATUS_WIDTH-1:0] wrap_status;

   // shared multiplier: running product times the current factor
   assign prod      = PW'(p_ff) * PW'(f_ff);
   assign prod_wrap = |prod[PW-1:RESULT_WIDTH];

   assign n_minus_r = req_n - req_r;
   assign k_sel     = (req_r < n_minus_r) ? req_r : n_minus_r;
   assign res_ext   = 64'(res_ff);

   assign wrap_status = wrap_ff ? STATUS_WRAP : STATUS_OK;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

   pcc_div #(
      .RESULT_WIDTH(RESULT_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(num_ff),
      .divisor (p_ff),
      .done    (div_done),
      .quotient(div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      f_in          = f_ff;
      k_in          = k_ff;
      p_in          = p_ff;
      num_in        = num_ff;
      wrap_in       = wrap_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               wrap_in = 1'b0;
               p_in    = RESULT_WIDTH'(1);
               f_in    = req_n;
               if (req_r > req_n) begin
                  res_in   = '0;
                  st_in    = STATUS_RANGE;
                  state_in = ST_OUT;
               end else begin
                  cnt_in   = req_mode ? k_sel : req_r;
                  k_in     = k_sel;
                  state_in = ST_NUM;
               end
            end
         end
         ST_NUM: begin
            if (cnt_ff == '0) begin
               if (!mode_ff) begin
                  res_in   = p_ff;
                  st_in    = wrap_status;
                  state_in = ST_OUT;
               end else begin
                  num_in   = p_ff;
                  p_in     = RESULT_WIDTH'(1);
                  f_in     = k_ff;
                  cnt_in   = k_ff;
                  state_in = ST_DEN;
               end
            end else begin
               p_in    = prod[RESULT_WIDTH-1:0];
               wrap_in = wrap_ff | prod_wrap;
               f_in    = f_ff - 1'b1;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         ST_DEN: begin
            if (cnt_ff == '0) begin
               if (p_ff == '0) begin
                  // divisor wrapped to zero
                  res_in   = '0;
                  st_in    = wrap_status;
                  state_in = ST_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               p_in    = prod[RESULT_WIDTH-1:0];
               wrap_in = wrap_ff | prod_wrap;
               f_in    = f_ff - 1'b1;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = div_quo;
               st_in    = wrap_status;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ext[OUT_WIDTH-1:0];
               rsp_status_in = st_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      cnt_ff        <= cnt_in;
      f_ff          <= f_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      num_ff        <= num_in;
      wrap_ff       <= wrap_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire
